@@ rtl/bsc_pkg.sv @@
// Shared definitions for the banker's safety check core.
// Sizes, field codes, state encoding and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package bsc_pkg;

	// Sizing of the stores and of the work vector.
	localparam int MAX_PROCS   = 16;
	localparam int MAX_RES     = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int WORK_W      = COUNT_WIDTH + 8;

	localparam int PROC_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int RES_W      = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
	localparam int PROC_CNT_W = $clog2(MAX_PROCS + 1);
	localparam int RES_CNT_W  = $clog2(MAX_RES + 1);
	localparam int CELL_AW    = PROC_W + RES_W;
	localparam int CELL_DEPTH = MAX_PROCS * MAX_RES;

	// Fixed widths of the word fields and of the configuration port.
	localparam int MODE_W     = 2;
	localparam int PROC_FLD_W = 4;
	localparam int RES_FLD_W  = 4;
	localparam int AMOUNT_W   = 16;
	localparam int CFG_W      = 5;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_PROCESSES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_RESOURCES = 1'd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD_CELL  = 2'd0,
		MODE_LOAD_AVAIL = 2'd1,
		MODE_RUN        = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_CHECK_END,
		ST_DECIDE,
		ST_ADD,
		ST_ADD_END,
		ST_ACCEPT,
		ST_NEXT,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              start;
		logic              rd_en;
		logic              rd_add;
		logic [PROC_W-1:0] proc_idx;
		logic [RES_W-1:0]  res_idx;
		logic              clear_fail;
		logic              accept;
		logic              finish;
		logic              final_safe;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fail;
		logic cur_finished;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

@@ rtl/bsc_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module bsc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/bsc_ctrl.sv @@
// Controller of the banker's safety check: configuration registers, loop counters
// and the sequencing state machine. Depends on bsc_pkg.
`default_nettype none

module bsc_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [bsc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [bsc_pkg::CFG_W-1:0]           cfg_wdata,
	input  wire logic                                item_valid,
	input  wire logic [bsc_pkg::MODE_W-1:0]          mode,
	output logic                                     item_stall,
	input  wire bsc_pkg::status_t                    st,
	output bsc_pkg::cmd_t                            cmd
);

	bsc_pkg::state_t state_q, state_d;

	logic [bsc_pkg::CFG_W-1:0]      num_proc_cfg_q, num_res_cfg_q;
	logic [bsc_pkg::PROC_CNT_W-1:0] np_q, np_d, count_q, count_d;
	logic [bsc_pkg::RES_CNT_W-1:0]  nr_q, nr_d;
	logic [bsc_pkg::PROC_W-1:0]     i_q, i_d, pass_q, pass_d;
	logic [bsc_pkg::RES_W-1:0]      r_q, r_d;
	logic                           last_res, last_proc, last_pass;
	logic [bsc_pkg::PROC_CNT_W-1:0] np_clamped;
	logic [bsc_pkg::RES_CNT_W-1:0]  nr_clamped;

	// A count of zero acts as one, a count beyond the store acts as its size.
	always_comb begin
		if (num_proc_cfg_q == '0) begin
			np_clamped = bsc_pkg::PROC_CNT_W'(1);
		end else if (32'(num_proc_cfg_q) > bsc_pkg::MAX_PROCS) begin
			np_clamped = bsc_pkg::PROC_CNT_W'(bsc_pkg::MAX_PROCS);
		end else begin
			np_clamped = bsc_pkg::PROC_CNT_W'(num_proc_cfg_q);
		end
		if (num_res_cfg_q == '0) begin
			nr_clamped = bsc_pkg::RES_CNT_W'(1);
		end else if (32'(num_res_cfg_q) > bsc_pkg::MAX_RES) begin
			nr_clamped = bsc_pkg::RES_CNT_W'(bsc_pkg::MAX_RES);
		end else begin
			nr_clamped = bsc_pkg::RES_CNT_W'(num_res_cfg_q);
		end
	end

	assign last_res  = (bsc_pkg::RES_CNT_W'(r_q) == nr_q - bsc_pkg::RES_CNT_W'(1));
	assign last_proc = (bsc_pkg::PROC_CNT_W'(i_q) == np_q - bsc_pkg::PROC_CNT_W'(1));
	assign last_pass = (bsc_pkg::PROC_CNT_W'(pass_q) == np_q - bsc_pkg::PROC_CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_proc_cfg_q <= bsc_pkg::CFG_RESET;
			num_res_cfg_q  <= bsc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			if (cfg_index == bsc_pkg::REG_NUM_PROCESSES) begin
				num_proc_cfg_q <= cfg_wdata;
			end else if (cfg_index == bsc_pkg::REG_NUM_RESOURCES) begin
				num_res_cfg_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsc_pkg::ST_IDLE;
			np_q    <= '0;
			nr_q    <= '0;
			count_q <= '0;
			i_q     <= '0;
			pass_q  <= '0;
			r_q     <= '0;
		end else begin
			state_q <= state_d;
			np_q    <= np_d;
			nr_q    <= nr_d;
			count_q <= count_d;
			i_q     <= i_d;
			pass_q  <= pass_d;
			r_q     <= r_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		np_d     = np_q;
		nr_d     = nr_q;
		count_d  = count_q;
		i_d      = i_q;
		pass_d   = pass_q;
		r_d      = r_q;
		cmd      = '0;
		cmd.proc_idx = i_q;
		cmd.res_idx  = r_q;
		item_stall   = (state_q != bsc_pkg::ST_IDLE);

		unique case (state_q)
			bsc_pkg::ST_IDLE: begin
				if (item_valid && (mode == bsc_pkg::MODE_RUN)) begin
					cmd.start = 1'b1;
					np_d      = np_clamped;
					nr_d      = nr_clamped;
					count_d   = '0;
					i_d       = '0;
					pass_d    = '0;
					state_d   = bsc_pkg::ST_SCAN;
				end
			end
			bsc_pkg::ST_SCAN: begin
				if (st.cur_finished) begin
					state_d = bsc_pkg::ST_NEXT;
				end else begin
					cmd.clear_fail = 1'b1;
					r_d            = '0;
					state_d        = bsc_pkg::ST_CHECK;
				end
			end
			bsc_pkg::ST_CHECK: begin
				cmd.rd_en = 1'b1;
				if (last_res) begin
					state_d = bsc_pkg::ST_CHECK_END;
				end else begin
					r_d = r_q + 1'b1;
				end
			end
			bsc_pkg::ST_CHECK_END: begin
				state_d = bsc_pkg::ST_DECIDE;
			end
			bsc_pkg::ST_DECIDE: begin
				if (st.fail) begin
					state_d = bsc_pkg::ST_NEXT;
				end else begin
					r_d     = '0;
					state_d = bsc_pkg::ST_ADD;
				end
			end
			bsc_pkg::ST_ADD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_add = 1'b1;
				if (last_res) begin
					state_d = bsc_pkg::ST_ADD_END;
				end else begin
					r_d = r_q + 1'b1;
				end
			end
			bsc_pkg::ST_ADD_END: begin
				state_d = bsc_pkg::ST_ACCEPT;
			end
			bsc_pkg::ST_ACCEPT: begin
				if (st.out_free) begin
					cmd.accept = 1'b1;
					count_d    = count_q + 1'b1;
					state_d    = bsc_pkg::ST_NEXT;
				end
			end
			bsc_pkg::ST_NEXT: begin
				state_d = bsc_pkg::ST_SCAN;
				if (last_proc) begin
					i_d = '0;
					if (last_pass) begin
						state_d = bsc_pkg::ST_DONE;
					end else begin
						pass_d = pass_q + 1'b1;
					end
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			bsc_pkg::ST_DONE: begin
				if (st.out_free) begin
					cmd.finish     = 1'b1;
					cmd.final_safe = (count_q == np_q);
					state_d        = bsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bsc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/bsc_datapath.sv @@
// Datapath of the banker's safety check: cell stores, available and work vectors,
// finished flags, the held result and the output register. Depends on bsc_pkg, bsc_ram.
`default_nettype none

module bsc_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                ld_en,
	input  wire logic [bsc_pkg::MODE_W-1:0]          mode,
	input  wire logic [bsc_pkg::PROC_FLD_W-1:0]      process,
	input  wire logic [bsc_pkg::RES_FLD_W-1:0]       resource,
	input  wire logic [bsc_pkg::AMOUNT_W-1:0]        allocated,
	input  wire logic [bsc_pkg::AMOUNT_W-1:0]        maximum,
	input  wire logic [bsc_pkg::AMOUNT_W-1:0]        available_amount,
	input  wire bsc_pkg::cmd_t                       cmd,
	output bsc_pkg::status_t                         st,
	input  wire logic                                result_stall,
	output logic                                     result_valid,
	output logic [bsc_pkg::PROC_FLD_W-1:0]           process_id,
	output logic                                     has_process,
	output logic                                     safe,
	output logic                                     last
);

	logic                                 ld_cell, ld_avail;
	logic [bsc_pkg::CELL_AW-1:0]          cell_waddr, cell_raddr;
	logic [bsc_pkg::COUNT_WIDTH-1:0]      alloc_rd, max_rd, need;
	logic [bsc_pkg::COUNT_WIDTH-1:0]      avail_q [bsc_pkg::MAX_RES];
	logic [bsc_pkg::WORK_W-1:0]           work_q [bsc_pkg::MAX_RES];
	logic [bsc_pkg::WORK_W-1:0]           work_cur, work_sat;
	logic [bsc_pkg::WORK_W:0]             work_sum;
	logic [bsc_pkg::MAX_PROCS-1:0]        fin_q;
	logic                                 fail_q;
	logic                                 rd_valid_s1, rd_add_s1;
	logic [bsc_pkg::RES_W-1:0]            rd_res_s1;
	logic                                 pend_valid_q;
	logic [bsc_pkg::PROC_W-1:0]           pend_id_q;
	logic                                 out_free;

	assign ld_cell  = ld_en && (mode == bsc_pkg::MODE_LOAD_CELL)
		&& (32'(process) < bsc_pkg::MAX_PROCS) && (32'(resource) < bsc_pkg::MAX_RES);
	assign ld_avail = ld_en && (mode == bsc_pkg::MODE_LOAD_AVAIL)
		&& (32'(resource) < bsc_pkg::MAX_RES);

	assign cell_waddr = {bsc_pkg::PROC_W'(process), bsc_pkg::RES_W'(resource)};
	assign cell_raddr = {cmd.proc_idx, cmd.res_idx};

	bsc_ram #(
		.WIDTH (bsc_pkg::COUNT_WIDTH),
		.DEPTH (bsc_pkg::CELL_DEPTH)
	) u_alloc_ram (
		.clk   (clk),
		.we    (ld_cell),
		.waddr (cell_waddr),
		.wdata (bsc_pkg::COUNT_WIDTH'(allocated)),
		.re    (cmd.rd_en),
		.raddr (cell_raddr),
		.rdata (alloc_rd)
	);

	bsc_ram #(
		.WIDTH (bsc_pkg::COUNT_WIDTH),
		.DEPTH (bsc_pkg::CELL_DEPTH)
	) u_max_ram (
		.clk   (clk),
		.we    (ld_cell),
		.waddr (cell_waddr),
		.wdata (bsc_pkg::COUNT_WIDTH'(maximum)),
		.re    (cmd.rd_en),
		.raddr (cell_raddr),
		.rdata (max_rd)
	);

	// Negative need never blocks, so it is taken as zero.
	assign need     = (max_rd > alloc_rd) ? (max_rd - alloc_rd) : '0;
	assign work_cur = work_q[rd_res_s1];
	assign work_sum = {1'b0, work_cur} + (bsc_pkg::WORK_W + 1)'(alloc_rd);
	assign work_sat = work_sum[bsc_pkg::WORK_W] ? '1 : work_sum[bsc_pkg::WORK_W-1:0];

	always_ff @(posedge clk) begin
		if (ld_avail) begin
			avail_q[bsc_pkg::RES_W'(resource)] <= bsc_pkg::COUNT_WIDTH'(available_amount);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int k = 0; k < bsc_pkg::MAX_RES; k++) begin
				work_q[k] <= bsc_pkg::WORK_W'(avail_q[k]);
			end
		end else if (rd_valid_s1 && rd_add_s1) begin
			work_q[rd_res_s1] <= work_sat;
		end
	end

	always_ff @(posedge clk) begin
		rd_add_s1 <= cmd.rd_add;
		rd_res_s1 <= cmd.res_idx;
		if (cmd.accept) begin
			pend_id_q <= cmd.proc_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1  <= 1'b0;
			fail_q       <= 1'b0;
			fin_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			if (cmd.clear_fail) begin
				fail_q <= 1'b0;
			end else if (rd_valid_s1 && !rd_add_s1
				&& (bsc_pkg::WORK_W'(need) > work_cur)) begin
				fail_q <= 1'b1;
			end
			if (cmd.start) begin
				fin_q        <= '0;
				pend_valid_q <= 1'b0;
			end else if (cmd.accept) begin
				fin_q[cmd.proc_idx] <= 1'b1;
				pend_valid_q        <= 1'b1;
			end
		end
	end

	// Output register: the held result moves here when the next one is found,
	// or with the final flags when the run ends.
	assign out_free = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if ((cmd.accept && pend_valid_q) || cmd.finish) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && pend_valid_q) begin
			process_id  <= bsc_pkg::PROC_FLD_W'(pend_id_q);
			has_process <= 1'b1;
			safe        <= 1'b0;
			last        <= 1'b0;
		end else if (cmd.finish) begin
			process_id  <= pend_valid_q ? bsc_pkg::PROC_FLD_W'(pend_id_q) : '0;
			has_process <= pend_valid_q;
			safe        <= pend_valid_q && cmd.final_safe;
			last        <= 1'b1;
		end
	end

	assign st.fail         = fail_q;
	assign st.cur_finished = fin_q[cmd.proc_idx];
	assign st.out_free     = out_free;

endmodule

`default_nettype wire

@@ rtl/bankers_safety_check_core.sv @@
// Top level of the banker's safety check core.
// Joins bsc_ctrl and bsc_datapath; depends on bsc_pkg, bsc_ram, bsc_ctrl, bsc_datapath.
//
//   Channel   Direction  Handshake                  Payload
//   item      in         item_valid / item_stall    mode, process, resource, allocated,
//                                                   maximum, available_amount
//   result    out        result_valid / result_stall process_id, has_process, safe, last
//   cfg       in         cfg_we (no wait)           cfg_index, cfg_wdata
//
// A load word (mode 0 or 1) is taken at once; a word with mode 3 is taken and dropped.
// A run word holds item_stall high until its final result has entered the output
// register. Each process visited in each pass reads its cells one resource per cycle
// through the single read port of the cell stores; a finished one is skipped. Every
// accepted process reads its cells once more to add its allocations to the work
// vector. A stalled result holds the next acceptance back. Reset clears the control
// state only; stores hold whatever was loaded.
`default_nettype none

module bankers_safety_check_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [bsc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [bsc_pkg::CFG_W-1:0]           cfg_wdata,
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire logic [bsc_pkg::MODE_W-1:0]          mode,
	input  wire logic [bsc_pkg::PROC_FLD_W-1:0]      process,
	input  wire logic [bsc_pkg::RES_FLD_W-1:0]       resource,
	input  wire logic [bsc_pkg::AMOUNT_W-1:0]        allocated,
	input  wire logic [bsc_pkg::AMOUNT_W-1:0]        maximum,
	input  wire logic [bsc_pkg::AMOUNT_W-1:0]        available_amount,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic [bsc_pkg::PROC_FLD_W-1:0]           process_id,
	output logic                                     has_process,
	output logic                                     safe,
	output logic                                     last
);

	bsc_pkg::cmd_t    cmd;
	bsc_pkg::status_t st;
	logic             item_accept;

	// Words are only taken while the controller is idle, so loads never meet a run.
	assign item_accept = item_valid && !item_stall;

	bsc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.mode       (mode),
		.item_stall (item_stall),
		.st         (st),
		.cmd        (cmd)
	);

	bsc_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ld_en            (item_accept),
		.mode             (mode),
		.process          (process),
		.resource         (resource),
		.allocated        (allocated),
		.maximum          (maximum),
		.available_amount (available_amount),
		.cmd              (cmd),
		.st               (st),
		.result_stall     (result_stall),
		.result_valid     (result_valid),
		.process_id       (process_id),
		.has_process      (has_process),
		.safe             (safe),
		.last             (last)
	);

	// A run word must take the block out of idle straight away.
	a_run_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		item_accept && (mode == bsc_pkg::MODE_RUN) |=> item_stall)
		else $error("run word accepted but input not stalled");

	// An empty result only ever closes a run.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_process |-> last)
		else $error("empty result without last");

	// The safe flag only rides on the final result of a run that accepted a process.
	a_safe_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && safe |-> last && has_process)
		else $error("safe flag on a non-final or empty result");

	// Once idle again, nothing but the final result of the run may still be waiting.
	a_idle_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		!item_stall && result_valid |-> last)
		else $error("intermediate result pending while idle");

endmodule

`default_nettype wire
